// ===== rtl/core/lscv_pkg.sv =====
// Package with shared constants, codes and control types of the victim select core.
`timescale 1ns / 1ps
package lscv_pkg;

    localparam int WAYS   = 16;
    localparam int SETS   = 1024;
    localparam int RK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WORD_W = WAYS * RK_W + WAYS;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 8;
    localparam int APB_AW     = 2;

    localparam logic [APB_AW-1:0] REG_TAG_AWARE = 2'd0;

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_INVALID   = 2'd0,
        KIND_UNTAGGED  = 2'd1,
        KIND_UNPROT    = 2'd2,
        KIND_ALL_PROT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/lscv_ctrl.sv =====
// Controller state machine of the victim select core.
`timescale 1ns / 1ps
module lscv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lscv_pkg::t_sts i_sts,
    output lscv_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import lscv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_EXEC: o_cmd.exec = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/lscv_dp.sv =====
// Datapath of the victim select core: set memory, item registers, policy logic, result register.
`timescale 1ns / 1ps
module lscv_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lscv_pkg::t_cmd               i_cmd,
    output lscv_pkg::t_sts               o_sts,
    input  logic                         i_tag_aware,
    input  logic                         i_op,
    input  logic [9:0]                   i_set_index,
    input  logic [3:0]                   i_way_index,
    input  logic                         i_was_hit,
    input  logic                         i_is_writeback,
    input  logic [15:0]                  i_valid_mask,
    input  logic [15:0]                  i_tagged_mask,
    input  logic                         i_protect_on_fill,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [3:0]                   o_victim_way,
    output logic [1:0]                   o_victim_kind
);
    import lscv_pkg::*;

    logic [WORD_W-1:0] mem [SETS];
    logic [WORD_W-1:0] r_rd;
    logic [SET_W-1:0]  r_clr_cnt;

    logic             r_op;
    logic [SET_W-1:0] r_set;
    logic [3:0]       r_way;
    logic             r_hit;
    logic             r_wb;
    logic [15:0]      r_valid;
    logic [15:0]      r_tag;
    logic             r_pfill;

    logic        r_out_valid;
    logic [3:0]  r_out_way;
    t_kind       r_out_kind;

    logic [WORD_W-1:0] c_clr_word;
    logic [WORD_W-1:0] c_word;
    logic [RK_W-1:0]   c_rank [WAYS];
    logic [RK_W-1:0]   c_way_at [WAYS];
    logic [WAYS-1:0]   c_prot;
    logic [WAYS-1:0]   c_elig;
    logic [WAYS-1:0]   c_present;
    logic              c_inv_found;
    logic [RK_W-1:0]   c_inv_way;
    logic              c_found;
    logic [RK_W-1:0]   c_sel_r;
    logic [RK_W-1:0]   c_vic;
    t_kind             c_kind;
    logic              c_way_ok;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            c_clr_word[w*RK_W +: RK_W] = RK_W'(w);
        end
        c_clr_word[WAYS*RK_W +: WAYS] = '0;
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            c_rank[w] = r_rd[w*RK_W +: RK_W];
        end
        c_prot = r_rd[WAYS*RK_W +: WAYS];

        // Map each rank back to the way that holds it; ranks form a permutation.
        c_present = '0;
        for (int r = 0; r < WAYS; r++) begin
            c_way_at[r] = '0;
            for (int w = 0; w < WAYS; w++) begin
                if (c_rank[w] == RK_W'(r)) begin
                    c_way_at[r]  = RK_W'(w);
                    c_present[r] = 1'b1;
                end
            end
        end

        c_inv_found = 1'b0;
        c_inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!r_valid[w]) begin
                c_inv_found = 1'b1;
                c_inv_way   = RK_W'(w);
            end
        end

        for (int w = 0; w < WAYS; w++) begin
            c_elig[w] = !r_tag[w] || !c_prot[w];
        end

        // Highest rank that is eligible wins, scanning from the LRU end.
        c_found = 1'b0;
        c_sel_r = '0;
        for (int r = WAYS - 1; r >= 0; r--) begin
            if (!c_found && c_elig[c_way_at[r]]) begin
                c_found = 1'b1;
                c_sel_r = RK_W'(r);
            end
        end

        c_way_ok = ({1'b0, r_way} < 5'(WAYS));
        c_word   = r_rd;
        c_vic    = '0;
        c_kind   = KIND_INVALID;

        if (r_op == OP_UPDATE) begin
            if (c_way_ok && !(r_wb && r_hit)) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (c_rank[w] < c_rank[r_way[RK_W-1:0]]) begin
                        c_word[w*RK_W +: RK_W] = c_rank[w] + RK_W'(1);
                    end
                end
                c_word[r_way[RK_W-1:0]*RK_W +: RK_W] = '0;
                if (r_hit) begin
                    if (i_tag_aware && r_tag[r_way[RK_W-1:0]]) begin
                        c_word[WAYS*RK_W + r_way[RK_W-1:0]] = 1'b1;
                    end
                end else begin
                    c_word[WAYS*RK_W + r_way[RK_W-1:0]] = r_pfill;
                end
            end
        end else if (c_inv_found) begin
            c_vic  = c_inv_way;
            c_kind = KIND_INVALID;
        end else if (!i_tag_aware) begin
            c_vic  = c_way_at[WAYS-1];
            c_kind = KIND_UNTAGGED;
        end else begin
            // Every way ranked above the pick was tagged and protected: disarm it.
            for (int w = 0; w < WAYS; w++) begin
                if (!c_found || (c_rank[w] > c_sel_r)) begin
                    c_word[WAYS*RK_W + w] = 1'b0;
                end
            end
            if (c_found) begin
                c_vic  = c_way_at[c_sel_r];
                c_kind = r_tag[c_way_at[c_sel_r]] ? KIND_UNPROT : KIND_UNTAGGED;
            end else begin
                c_vic  = c_way_at[WAYS-1];
                c_kind = KIND_ALL_PROT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_cnt] <= c_clr_word;
        end else if (i_cmd.exec) begin
            mem[r_set] <= c_word;
        end
        if (i_cmd.accept) begin
            r_rd <= mem[i_set_index[SET_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + SET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_set   <= i_set_index[SET_W-1:0];
            r_way   <= i_way_index;
            r_hit   <= i_was_hit;
            r_wb    <= i_is_writeback;
            r_valid <= i_valid_mask;
            r_tag   <= i_tagged_mask;
            r_pfill <= i_protect_on_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && r_op == OP_QUERY) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == OP_QUERY) begin
            r_out_way  <= 4'(c_vic);
            r_out_kind <= c_kind;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == SET_W'(SETS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_victim_way   = r_out_way;
    assign o_victim_kind  = r_out_kind;

    // A new result only ever follows an executed query.
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.exec && r_op == OP_QUERY))
        else $error("result raised without a query");

    // Ranks of an executed set stay a permutation.
    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (&c_present))
        else $error("rank word is not a permutation");

    // An invalid-way result names a way whose valid bit was clear.
    a_inv_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_QUERY && c_kind == KIND_INVALID) |-> !r_valid[c_vic])
        else $error("invalid-way victim was valid");

    // Item accepts and executes never overlap the clearing pass.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clr && (i_cmd.exec || i_cmd.accept)))
        else $error("clear overlaps item work");

endmodule

// ===== rtl/core/lru_second_chance_victim_select_core.sv =====
// Top level of the LRU victim select core with second-chance protection.
`timescale 1ns / 1ps
// Usage:
// Items arrive as beats on the s_axis channel. tuser carries the operation
// (query or update); tdata carries the set, way, hit and writeback flags,
// the valid and tag masks and the fill protect value. Every query gives one
// result beat on the m_axis channel: the victim way in tdata and the kind
// of victim in tuser. Updates give no result beat.
// For each item the set's rank and protect word is read from the set memory
// into a register when the beat is accepted, and the policy logic writes it
// back in the execute step while loading the result register. One item is
// in flight at a time. The result register lets the next item be accepted
// while a result waits. If the receiver stalls, the next item holds in the
// execute step until the result register frees, and no further beat is
// accepted meanwhile. After reset the set memory is swept once to its reset
// contents, one set per cycle, during which tready stays low. The APB
// register tag_aware_enable (offset 0, reset 1) is to be written by the user
// only while idle; the block itself does not enforce this.
module lru_second_chance_victim_select_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] set_index, [13:10] way_index, [14] was_hit, [15] is_writeback,
    // [31:16] valid_mask, [47:32] tagged_mask, [48] protect_on_fill, rest zero
    input  logic [lscv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] victim_way, rest zero
    output logic [lscv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] victim_kind
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lscv_pkg::APB_AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lscv_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic       r_tag_aware;
    logic [3:0] victim_way;

    // Configuration register: written on the APB access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_aware <= 1'b1;
        end else if (psel && penable && pwrite && paddr == REG_TAG_AWARE) begin
            r_tag_aware <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TAG_AWARE) ? {31'd0, r_tag_aware} : 32'd0;

    lscv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    lscv_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_tag_aware       (r_tag_aware),
        .i_op              (s_axis_tuser),
        .i_set_index       (s_axis_tdata[9:0]),
        .i_way_index       (s_axis_tdata[13:10]),
        .i_was_hit         (s_axis_tdata[14]),
        .i_is_writeback    (s_axis_tdata[15]),
        .i_valid_mask      (s_axis_tdata[31:16]),
        .i_tagged_mask     (s_axis_tdata[47:32]),
        .i_protect_on_fill (s_axis_tdata[48]),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_victim_way      (victim_way),
        .o_victim_kind     (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, victim_way};

endmodule
